/* src/rmf_pkg.sv */
// Shared types, constants and register codes for the ratio median filter.
// No dependencies; every other file of the block imports this package.
package rmf_pkg;

   // Field widths.
   localparam int CapW    = 32;
   localparam int GainW   = 24;
   localparam int SampleW = 32;
   localparam int ProdW   = CapW + GainW;
   localparam int DivW    = 64;

   // Quotient bits retired per divider cycle.
   localparam int DivBits = 2;

   // Default window length (number of samples per median).
   localparam int WindowDefault = 11;

   // Register reset values.
   localparam logic [GainW-1:0] GainReset   = 24'd100000;
   localparam logic [GainW-1:0] OffsetReset = 24'd99625;

   // Register indexes on the configuration port.
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CsrGain   = 1'd0;
   localparam logic [CsrIdxW-1:0] CsrOffset = 1'd1;

   // Saturation limits of a sample.
   localparam logic signed [SampleW-1:0] SampleMax = 32'sh7FFF_FFFF;
   localparam logic signed [SampleW-1:0] SampleMin = 32'sh8000_0000;

   typedef logic signed [SampleW-1:0] sample_type;

   // Controls broadcast to one sorting cell.
   typedef struct packed {
      logic load;        // a new sample is being inserted this cycle
      logic held;        // this cell holds a sample of the current window
      logic left_stays;  // left neighbor keeps its value (or this is the first cell)
   } cell_ctrl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_SAT,
      ST_EMIT
   } state_type;

endpackage

/* src/ratio_median_filter_top.sv */
// Top level of the ratio median filter: sample forming, divider, sorting chain.
// Depends on rmf_pkg, rmf_divider and rmf_sort_cell.
//
//  Channel | Direction | Transfer on            | Contents
//  req_    | in        | req_tvalid & tready    | tdata: cap_a, cap_b
//  rsp_    | out       | rsp_tvalid & tready    | tdata: median_value; tuser: clipped
//  csr_    | in        | csr_we                 | csr_addr: index, csr_wdata: value
//
// Each item passes through accept, multiply, divider load, the radix-4 divider
// iterations, the divider's done flag, saturate and insert. An item with a zero
// divisor skips the divider. The item that completes a window also loads the
// output register. Reset clears the sequencer, the fill count, the clip flag and
// the output valid flag, and loads the configuration registers' reset values.
// A result waiting in the output register only stalls the window-closing item.
module ratio_median_filter_top
   import rmf_pkg::*;
#(
   parameter int WINDOW = WindowDefault
)(
   input  logic               clock,
   input  logic               reset,
   // Request stream.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2*CapW-1:0]  req_tdata,   // [31:0] cap_a, [63:32] cap_b
   // Response stream.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [SampleW-1:0] rsp_tdata,   // [31:0] median_value
   output logic               rsp_tuser,   // [0] clipped
   // Configuration writes.
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_addr,
   input  logic [GainW-1:0]   csr_wdata
);

   localparam int CntW   = $clog2(WINDOW + 1);
   localparam int MedIdx = (WINDOW - 1) / 2;

   state_type state_ff, state_in;

   logic [GainW-1:0]   gain_ff, offset_ff;
   logic [CapW-1:0]    cap_a_ff, cap_b_ff;
   logic [ProdW-1:0]   prod_ff;
   logic [CntW-1:0]    count_ff, count_in;
   logic               clip_seen_ff, clip_seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sample_type         rsp_data_ff, rsp_data_in;
   logic               rsp_clip_ff, rsp_clip_in;

   logic               accept;
   logic               div_start;
   logic               insert_en;
   logic               emit_fire;
   logic               div_done;
   logic [DivW-1:0]    quotient;

   sample_type         sample;
   logic               sample_clip;
   sample_type         cell_value [WINDOW];
   logic               cell_stays [WINDOW];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GainReset;
         offset_ff <= OffsetReset;
      end else if (csr_we) begin
         case (csr_addr)
            CsrGain:   gain_ff   <= csr_wdata;
            CsrOffset: offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_START;
         ST_START: state_in = (cap_b_ff == '0) ? ST_SAT : ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_SAT;
         ST_SAT:   state_in = (count_ff == CntW'(WINDOW - 1)) ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      insert_en  = 1'b0;
      emit_fire  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_START: div_start  = (cap_b_ff != '0);
         ST_SAT:   insert_en  = 1'b1;
         ST_EMIT:  emit_fire  = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the readings and form the scaled numerator.
   always_ff @(posedge clock) begin
      if (accept) begin
         cap_a_ff <= req_tdata[CapW-1:0];
         cap_b_ff <= req_tdata[2*CapW-1:CapW];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= cap_a_ff * gain_ff;
      end
   end

   rmf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({prod_ff, 8'b0}),
      .divisor  (cap_b_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Subtract the offset and saturate; a zero divisor gives the positive limit.
   always_comb begin
      logic [CapW:0]           off_q;
      logic [CapW:0]           limit;
      logic signed [CapW+1:0]  diff;
      off_q       = {1'b0, offset_ff, 8'b0};
      limit       = {1'b0, 32'h7FFF_FFFF} + off_q;
      diff        = $signed({1'b0, quotient[CapW:0]}) - $signed({1'b0, off_q});
      sample      = SampleMax;
      sample_clip = 1'b1;
      if (cap_b_ff == '0) begin
         sample      = SampleMax;
         sample_clip = 1'b1;
      end else if ((quotient[DivW-1:CapW+1] != '0) || (quotient[CapW:0] > limit)) begin
         sample      = SampleMax;
         sample_clip = 1'b1;
      end else if (diff < $signed({{2{1'b1}}, SampleMin})) begin
         sample      = SampleMin;
         sample_clip = 1'b1;
      end else begin
         sample      = diff[SampleW-1:0];
         sample_clip = 1'b0;
      end
   end

   // Sorting chain: each cell compares against the new sample and shifts right.
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      cell_ctrl_type ctrl;
      sample_type    left_value;

      assign ctrl.load       = insert_en;
      assign ctrl.held       = (CntW'(k) < count_ff);
      if (k == 0) begin : g_first
         assign ctrl.left_stays = 1'b1;
         assign left_value      = sample;
      end else begin : g_rest
         assign ctrl.left_stays = cell_stays[k-1];
         assign left_value      = cell_value[k-1];
      end

      rmf_sort_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_sample (sample),
         .left_value (left_value),
         .stays      (cell_stays[k]),
         .value      (cell_value[k])
      );
   end

   // Fill count, clip flag and output register.
   always_comb begin
      count_in     = count_ff;
      clip_seen_in = clip_seen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (insert_en) begin
         count_in     = count_ff + 1'b1;
         clip_seen_in = clip_seen_ff | sample_clip;
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cell_value[MedIdx];
         rsp_clip_in  = clip_seen_ff;
         count_in     = '0;
         clip_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clip_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clip_seen_ff <= clip_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clip_ff;

endmodule

/* src/rmf_divider.sv */
// Iterative unsigned 64 / 32 restoring divider, DivBits quotient bits a cycle.
// Depends on rmf_pkg.
module rmf_divider
   import rmf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DivW-1:0] dividend,
   input  logic [CapW-1:0] divisor,
   output logic            done,
   output logic [DivW-1:0] quotient
);

   localparam int Steps = DivW / DivBits;
   localparam int CntW  = $clog2(Steps);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [DivW-1:0] quo_ff, quo_in;
   logic [CapW-1:0] rem_ff, rem_in;
   logic [CapW-1:0] den_ff, den_in;
   logic [DivW-1:0] quo_step;
   logic [CapW-1:0] rem_step;

   // DivBits restoring steps: shift in one dividend bit, try to subtract.
   always_comb begin
      logic [CapW:0] trial;
      quo_step = quo_ff;
      rem_step = rem_ff;
      for (int i = 0; i < DivBits; i++) begin
         trial    = {rem_step, quo_step[DivW-1]};
         quo_step = {quo_step[DivW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_step    = CapW'(trial - {1'b0, den_ff});
            quo_step[0] = 1'b1;
         end else begin
            rem_step = trial[CapW-1:0];
         end
      end
   end

   // Load on start, then iterate until the count runs out.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(Steps - 1);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/rmf_sort_cell.sv */
// One cell of the insertion sorting chain; the chain keeps samples in
// descending order, cells below an inserted sample passing theirs right.
// Depends on rmf_pkg.
module rmf_sort_cell
   import rmf_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  sample_type    new_sample,
   input  sample_type    left_value,
   output logic          stays,
   output sample_type    value
);

   sample_type value_ff, value_in;

   // A held value not below the new sample keeps its place.
   assign stays = ctrl.held && (value_ff >= new_sample);

   // Otherwise take the new sample at the insertion point, or shift right.
   always_comb begin
      value_in = value_ff;
      if (ctrl.load && !stays) begin
         value_in = ctrl.left_stays ? new_sample : left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* verif/ratio_median_filter_checker.sv */
// Checker for the ratio median filter: watches the request, response and register
// channels, predicts each median and compares it with the response transfers.
// Depends on rmf_pkg for widths, register codes and saturation limits.
`timescale 1ns / 1ps
module ratio_median_filter_checker
   import rmf_pkg::*;
#(
   parameter int WINDOW = WindowDefault
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [2*CapW-1:0]  req_tdata,   // [31:0] cap_a, [63:32] cap_b
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [SampleW-1:0] rsp_tdata,   // [31:0] median_value
   input  logic               rsp_tuser,   // [0] clipped
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_addr,
   input  logic [GainW-1:0]   csr_wdata,
   output int                 fault_count,
   output int                 medians_pending,
   output int                 medians_checked,
   output int                 clipped_medians
);

   typedef struct packed {
      sample_type median;
      logic       clipped;
   } median_result_type;

   // Shadow copy of the registers and of the sample window.
   logic [GainW-1:0]  gain;
   logic [GainW-1:0]  offset;
   sample_type        window_samples [WINDOW];
   int                window_fill;
   logic              window_clipped;
   median_result_type expected_medians [$];
   int                faults;
   int                checked;
   int                clipped_seen;

   // Scaled ratio gain * num / den in Q24.8 minus the offset, saturated to 32 bits.
   function automatic sample_type scaled_ratio(input logic [CapW-1:0] num,
                                               input logic [CapW-1:0] den,
                                               output logic sat);
      logic [63:0] quot;
      logic [63:0] bias;
      longint      diff;
      sat = 1'b0;
      if (den == '0) begin
         sat = 1'b1;
         return SampleMax;
      end
      quot = ({32'd0, num} * {40'd0, gain}) << 8;
      quot = quot / {32'd0, den};
      bias = {32'd0, offset, 8'd0};
      if (quot > 64'h7FFF_FFFF + bias) begin
         sat = 1'b1;
         return SampleMax;
      end
      diff = longint'(quot) - longint'(bias);
      if (diff < longint'(SampleMin)) begin
         sat = 1'b1;
         return SampleMin;
      end
      return sample_type'(diff[SampleW-1:0]);
   endfunction

   // Middle entry of the window ranked from largest to smallest.
   function automatic sample_type window_median();
      sample_type ranked [WINDOW];
      sample_type swap;
      ranked = window_samples;
      for (int pass = 0; pass < WINDOW - 1; pass++) begin
         for (int k = 0; k < WINDOW - 1 - pass; k++) begin
            if (ranked[k] < ranked[k+1]) begin
               swap        = ranked[k];
               ranked[k]   = ranked[k+1];
               ranked[k+1] = swap;
            end
         end
      end
      return ranked[(WINDOW-1)/2];
   endfunction

   always @(posedge clock) begin
      median_result_type want;
      sample_type        fresh;
      logic              fresh_sat;
      if (reset) begin
         gain           = GainReset;
         offset         = OffsetReset;
         window_fill    = 0;
         window_clipped = 1'b0;
         faults         = 0;
         checked        = 0;
         clipped_seen   = 0;
         expected_medians.delete();
      end else begin
         // Compare a response transfer with the oldest predicted median.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_medians.size() == 0) begin
               $error("median transfer 0x%08h arrived with none pending", rsp_tdata);
               faults++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_tdata !== want.median) begin
                  $error("median_value: expected %0d, got %0d",
                         want.median, $signed(rsp_tdata));
                  faults++;
               end
               if (rsp_tuser !== want.clipped) begin
                  $error("clipped: expected %0b, got %0b", want.clipped, rsp_tuser);
                  faults++;
               end
               checked++;
               if (want.clipped) begin
                  clipped_seen++;
               end
            end
         end

         // Register writes.
         if (csr_we) begin
            case (csr_addr)
               CsrGain:   gain = csr_wdata;
               CsrOffset: offset = csr_wdata;
               default: ;
            endcase
         end

         // A request transfer adds one sample; a full window yields one median.
         if (req_tvalid && req_tready) begin
            fresh = scaled_ratio(req_tdata[CapW-1:0], req_tdata[2*CapW-1:CapW], fresh_sat);
            window_samples[window_fill] = fresh;
            window_fill++;
            window_clipped = window_clipped | fresh_sat;
            if (window_fill == WINDOW) begin
               want.median  = window_median();
               want.clipped = window_clipped;
               expected_medians.push_back(want);
               window_fill    = 0;
               window_clipped = 1'b0;
            end
         end
      end
      fault_count     <= faults;
      medians_pending <= expected_medians.size();
      medians_checked <= checked;
      clipped_medians <= clipped_seen;
   end

endmodule

/* verif/ratio_median_filter_top_test.sv */
// Testbench top for the ratio median filter: clock, reset, capacitance pair
// stimulus, register settings, response back-pressure and the final verdict.
// Depends on rmf_pkg, ratio_median_filter_top and ratio_median_filter_checker.
`timescale 1ns / 1ps
module ratio_median_filter_top_test
   import rmf_pkg::*;
();

   localparam int PhaseItems     = 136;
   localparam int PhaseCount     = 9;
   localparam int SinkHoldCycles = 2500;
   localparam int DrainCycles    = 48;
   localparam int WatchdogLimit  = 10000;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [2*CapW-1:0]  req_tdata;   // [31:0] cap_a, [63:32] cap_b
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [SampleW-1:0] rsp_tdata;   // [31:0] median_value
   logic               rsp_tuser;   // [0] clipped
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_addr;
   logic [GainW-1:0]   csr_wdata;

   int               fault_count;
   int               medians_pending;
   int               medians_checked;
   int               clipped_medians;
   logic [GainW-1:0] cur_gain;
   logic [GainW-1:0] cur_offset;
   int               feed_run;
   int               sink_run;
   bit               sink_hold_request;
   int               idle_count;
   int               pairs_sent;
   int               settings_used;

   ratio_median_filter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ratio_median_filter_checker median_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fault_count     (fault_count),
      .medians_pending (medians_pending),
      .medians_checked (medians_checked),
      .clipped_medians (clipped_medians)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Idle length for one side: mostly none or short, now and then long,
   // with occasional runs of back-to-back transfers.
   function automatic int idle_cycles(inout int run_left);
      int unsigned roll;
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         run_left = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Offer one capacitance pair and wait for its transfer.
   task automatic send_pair(input logic [CapW-1:0] a, input logic [CapW-1:0] b);
      int gap;
      gap = idle_cycles(feed_run);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      do @(posedge clock); while (!req_tready);
      pairs_sent++;
   endtask

   // Stop offering, wait for every pending median, then let the pipeline empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (medians_pending != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write both registers on consecutive cycles.
   task automatic write_settings(input logic [GainW-1:0] g, input logic [GainW-1:0] o);
      csr_we    <= 1'b1;
      csr_addr  <= CsrGain;
      csr_wdata <= g;
      @(posedge clock);
      csr_addr  <= CsrOffset;
      csr_wdata <= o;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_gain   = g;
      cur_offset = o;
      settings_used++;
   endtask

   // Random pair. Most pairs are aimed so that gain * a / b lands near the
   // offset, which keeps samples inside the range and the medians meaningful.
   task automatic random_pair(output logic [CapW-1:0] a, output logic [CapW-1:0] b);
      int unsigned pick;
      longint      target;
      longint      spread;
      pick = $urandom_range(0, 99);
      a = $urandom;
      b = $urandom;
      if (pick < 55 && cur_gain != '0) begin
         b = $urandom >> $urandom_range(0, 31);
         if (b == '0) b = 1;
         target = (longint'(b) * longint'(cur_offset)) / longint'(cur_gain);
         if (target > 64'hFFFF_FFFF) target = 64'hFFFF_FFFF;
         spread = target / 32 + 4;
         target = target + longint'($urandom_range(0, 32'(2 * spread))) - spread;
         if (target < 0) target = 0;
         if (target > 64'hFFFF_FFFF) target = 64'hFFFF_FFFF;
         a = target[CapW-1:0];
      end else if (pick < 80) begin
         // Fully random pair, already drawn.
      end else if (pick < 88) begin
         b = '0;
      end else if (pick < 94) begin
         case ($urandom_range(0, 2))
            0: a = '0;
            1: a = 1;
            default: a = '1;
         endcase
         case ($urandom_range(0, 2))
            0: b = 1;
            1: b = '1;
            default: ;
         endcase
      end else begin
         a = $urandom_range(0, 255);
         b = $urandom_range(1, 255);
      end
   endtask

   // Response side: random back-pressure, plus one long hold on request.
   initial begin : response_sink
      int hold;
      forever begin
         if (sink_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (SinkHoldCycles) @(posedge clock);
            sink_hold_request = 1'b0;
         end
         hold = idle_cycles(sink_run);
         if (hold == 0) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_count <= 0;
      end else if (idle_count == WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin : stimulus
      logic [CapW-1:0]  a;
      logic [CapW-1:0]  b;
      logic [GainW-1:0] gain_plan [PhaseCount];
      logic [GainW-1:0] offset_plan [PhaseCount];
      gain_plan   = '{GainReset, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd1,
                      24'd0, 24'd0, 24'd0};
      offset_plan = '{OffsetReset, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0, 24'd0,
                      24'd0, 24'd0, 24'd0};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CsrGain;
      csr_wdata  <= '0;
      cur_gain      = GainReset;
      cur_offset    = OffsetReset;
      settings_used = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: in-range samples only, from the most negative (zero
      // numerator) to just under the positive limit (ratio 84).
      send_pair(32'h0001_0000, 32'h0001_0000);
      send_pair(32'h0000_0000, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'h0000_0001, 32'h0000_0001);
      send_pair(32'h0001_0100, 32'h0001_0000);
      send_pair(32'h0000_FF00, 32'h0001_0000);
      send_pair(32'h0000_0000, 32'h0000_0001);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'd84, 32'd1);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_pair(32'h1234_5678, 32'h2345_6789);
      settle();

      // Small gain and full offset: zero divisors, then overflow and underflow,
      // each of the latter next to the pair just inside its limit.
      write_settings(24'd1000, 24'hFFFFFF);
      send_pair(32'h0000_0000, 32'h0000_0000);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000);
      send_pair(32'hFFFF_FFFF, 32'h0000_0001);
      send_pair(32'h0000_0000, 32'h0000_0001);
      send_pair(32'd25166, 32'd1);
      send_pair(32'd25165, 32'd1);
      send_pair(32'd8389, 32'd1);
      send_pair(32'd8388, 32'd1);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'h0000_0001, 32'h0000_0001);
      send_pair(32'h00FF_FFFF, 32'h0000_0100);
      settle();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         if (phase >= 6) begin
            gain_plan[phase]   = GainW'($urandom_range(0, 24'hFFFFFF));
            offset_plan[phase] = GainW'($urandom_range(0, 24'hFFFFFF));
         end
         write_settings(gain_plan[phase], offset_plan[phase]);
         for (int n = 0; n < PhaseItems; n++) begin
            // Hold the response side off long enough for the input to stall.
            if (phase == 3 && n == 20) sink_hold_request = 1'b1;
            random_pair(a, b);
            send_pair(a, b);
         end
         settle();
      end

      $display("Checked %0d medians (%0d flagged as clipped) from %0d capacitance pairs",
               medians_checked, clipped_medians, pairs_sent);
      $display("under %0d register settings, zero and full-scale gain and offset among them.",
               settings_used);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
